// File: src/tmm_pkg.sv
// Shared types and constants for the ternary mask match table.
// No dependencies; imported by tmm_front, tmm_back and ternary_mask_match_table.
`timescale 1ns / 1ps
`default_nettype none

package tmm_pkg;

  // default geometry
  localparam int ENTRIES_DEF   = 32;
  localparam int WORD_BITS_DEF = 32;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command carried on tuser
  localparam logic CMD_SEARCH = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  // result word: hit, then status, padded to one byte
  localparam int OUT_BITS    = 3;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic vld;
    logic is_add;
  } req_ctrl_t;

  // back end status for the top level
  typedef struct packed {
    logic busy;
    logic full;
  } eng_stat_t;

endpackage

`default_nettype wire

// File: src/ternary_mask_match_table.sv
// Top level of the ternary mask match table: front end, request queue, back end.
// Depends on tmm_pkg, tmm_front and tmm_back.
`timescale 1ns / 1ps
`default_nettype none

// Ternary match table of WORD_BITS-bit entries, ENTRIES slots. An add word
// (tuser = 1) stores care = ~dont_care and value = word & care in the next
// free slot; an add equal to a stored pair reports duplicate, even when the
// table is full; any other add to a full table reports full and changes
// nothing. A search word (tuser = 0) reports hit when some stored entry has
// (word & care) == value. Every word in gives exactly one result word out.
// The front end takes words into a two-deep request queue; the back end
// scans stored entries through the single read port of the entry memory,
// one entry per cycle. The table needs no clearing pass: entries fill in
// order and only slots below the fill count are ever read. A finished
// result sits in an output register, so the next request is already
// scanning while the result waits.

module ternary_mask_match_table #(
  parameter int ENTRIES    = tmm_pkg::ENTRIES_DEF,
  parameter int WORD_BITS  = tmm_pkg::WORD_BITS_DEF,
  parameter int IN_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [WORD_BITS-1:0] word, [2*WORD_BITS-1:WORD_BITS] dont_care, rest zero
  input  wire logic [IN_TDATA_W-1:0]       s_axis_tdata_i,
  // [0] cmd: 0 search, 1 add
  input  wire logic                        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // [0] hit, [2:1] status (0 ok, 1 duplicate, 2 full), [7:3] zero
  output logic [tmm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import tmm_pkg::*;

  req_ctrl_t            q_ctrl;
  logic [WORD_BITS-1:0] q_word, q_care;
  logic                 q_pop;
  eng_stat_t            stat;

  tmm_front #(
    .WORD_BITS  (WORD_BITS),
    .IN_TDATA_W (IN_TDATA_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_ctrl_o        (q_ctrl),
    .q_word_o        (q_word),
    .q_care_o        (q_care),
    .q_pop_i         (q_pop)
  );

  tmm_back #(
    .ENTRIES   (ENTRIES),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_ctrl_i        (q_ctrl),
    .q_word_i        (q_word),
    .q_care_i        (q_care),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .stat_o          (stat)
  );

  // a pop only happens when the queue holds a request and the engine is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_ctrl.vld && !stat.busy))
    else $error("request popped while engine busy or queue empty");

  // the table only fills; full never clears without reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(stat.full))
    else $error("table full flag dropped");

  // a new result only comes out of the engine's finishing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(stat.busy))
    else $error("result word without a request in flight");

  // a hit is only reported with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[2:1] == STATUS_OK))
    else $error("hit reported on an add result");

endmodule

`default_nettype wire

// File: src/tmm_front.sv
// Front end: accepts words, splits command/value/mask and queues requests.
// Depends on tmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmm_front #(
  parameter int WORD_BITS  = tmm_pkg::WORD_BITS_DEF,
  parameter int IN_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,
  output tmm_pkg::req_ctrl_t         q_ctrl_o,
  output logic [WORD_BITS-1:0]       q_word_o,
  output logic [WORD_BITS-1:0]       q_care_o,
  input  wire logic                  q_pop_i
);
  import tmm_pkg::*;

  logic [WORD_BITS-1:0] word_mem [QUEUE_DEPTH];
  logic [WORD_BITS-1:0] care_mem [QUEUE_DEPTH];
  logic                 add_mem  [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  logic                 push, pop, in_add;
  logic [WORD_BITS-1:0] in_word, in_care;

  // classify: adds store the value already masked by the care bits
  assign in_add  = (s_axis_tuser_i == CMD_ADD);
  assign in_care = ~s_axis_tdata_i[2*WORD_BITS-1:WORD_BITS];
  assign in_word = in_add ? (s_axis_tdata_i[WORD_BITS-1:0] & in_care)
                          : s_axis_tdata_i[WORD_BITS-1:0];

  assign s_axis_tready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push = s_axis_tvalid_i & s_axis_tready_o;
  assign pop  = q_pop_i & (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      word_mem[wr_ptr_q] <= in_word;
      care_mem[wr_ptr_q] <= in_care;
      add_mem[wr_ptr_q]  <= in_add;
    end
  end

  assign q_ctrl_o.vld    = (cnt_q != '0);
  assign q_ctrl_o.is_add = add_mem[rd_ptr_q];
  assign q_word_o        = word_mem[rd_ptr_q];
  assign q_care_o        = care_mem[rd_ptr_q];

endmodule

`default_nettype wire

// File: src/tmm_back.sv
// Back end: entry memory, sequential scan over stored entries, add/result logic.
// Depends on tmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmm_back #(
  parameter int ENTRIES   = tmm_pkg::ENTRIES_DEF,
  parameter int WORD_BITS = tmm_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tmm_pkg::req_ctrl_t          q_ctrl_i,
  input  wire logic [WORD_BITS-1:0]        q_word_i,
  input  wire logic [WORD_BITS-1:0]        q_care_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [tmm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output tmm_pkg::eng_stat_t               stat_o
);
  import tmm_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // entry store, filled in order: slot i is valid when i < cnt_q
  logic [WORD_BITS-1:0] mem_value [ENTRIES];
  logic [WORD_BITS-1:0] mem_care  [ENTRIES];
  logic [WORD_BITS-1:0] rd_value_q, rd_care_q;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic             rd_vld_q, rd_en, wr_en, load;
  logic             out_vld_q, out_vld_d, out_load;
  logic             out_hit_q, out_hit_d;
  status_e          out_status_q, out_status_d;

  logic                 cur_add_q;
  logic [WORD_BITS-1:0] cur_word_q, cur_care_q;
  logic                 match, full;

  assign full = (cnt_q == CNT_W'(ENTRIES));

  // add: exact pair compare; search: masked compare
  assign match = cur_add_q ? ((rd_value_q == cur_word_q) && (rd_care_q == cur_care_q))
                           : ((cur_word_q & rd_care_q) == rd_value_q);

  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    cnt_d        = cnt_q;
    found_d      = found_q | (rd_vld_q & match);
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    load         = 1'b0;
    q_pop_o      = 1'b0;
    out_load     = 1'b0;
    out_vld_d    = out_vld_q & ~m_axis_tready_i;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_ctrl_i.vld) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          issue_d = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q != cnt_q) begin
          rd_en   = 1'b1;
          issue_d = issue_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if (cur_add_q) begin
            out_hit_d = 1'b0;
            priority if (found_q) begin
              out_status_d = STATUS_DUP;
            end else if (full) begin
              out_status_d = STATUS_FULL;
            end else begin
              out_status_d = STATUS_OK;
              wr_en        = 1'b1;
              cnt_d        = cnt_q + CNT_W'(1);
            end
          end else begin
            out_hit_d    = found_q;
            out_status_d = STATUS_OK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      rd_vld_q  <= rd_en;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_add_q  <= q_ctrl_i.is_add;
      cur_word_q <= q_word_i;
      cur_care_q <= q_care_i;
    end
    if (out_load) begin
      out_hit_q    <= out_hit_d;
      out_status_q <= out_status_d;
    end
  end

  // single port entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_value[cnt_q[IDX_W-1:0]] <= cur_word_q;
      mem_care[cnt_q[IDX_W-1:0]]  <= cur_care_q;
    end
    if (rd_en) begin
      rd_value_q <= mem_value[issue_q[IDX_W-1:0]];
      rd_care_q  <= mem_care[issue_q[IDX_W-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_status_q, out_hit_q});
  assign stat_o.busy     = (state_q != ST_IDLE);
  assign stat_o.full     = full;

endmodule

`default_nettype wire
